// ----- rtl/core/adpu_pkg.sv -----
// Shared constants, types and arithmetic helpers for the Adadelta update unit.
// Used by the top level, the pipelined square root, the divider and the checker.
package adpu_pkg;

  localparam int unsigned ELEMENTS   = 4096;
  localparam int unsigned IDX_W      = $clog2(ELEMENTS);
  localparam int unsigned IN_IDX_W   = 12;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned FRAC_W     = 24;
  localparam int unsigned RHO_W      = 16;
  localparam int unsigned EPS_W      = 21;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned SQ_W   = 2 * DATA_W - 1 - FRAC_W;
  localparam int unsigned PA_W   = RHO_W + DATA_W;
  localparam int unsigned PB_W   = RHO_W + 1 + SQ_W;
  localparam int unsigned ACC_W  = PB_W + 1;
  localparam int unsigned RAD_W  = DATA_W + FRAC_W;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned PROD_W = ROOT_W + DATA_W;

  localparam int unsigned SQRT_BPS = 4;
  localparam int unsigned SQRT_STG = ROOT_W / SQRT_BPS;
  localparam int unsigned DIV_BPS  = 4;
  localparam int unsigned DIV_STG  = DATA_W / DIV_BPS;

  localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STABILITY_TERM = CFG_IDX_W'(1);

  localparam logic [RHO_W-1:0]  DECAY_RESET = RHO_W'(62259);
  localparam logic [EPS_W-1:0]  STAB_RESET  = EPS_W'(17);
  localparam logic [RHO_W:0]    ONE_Q16     = (RHO_W+1)'(1) << RHO_W;
  localparam logic [DATA_W-1:0] AVG_MAX     = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MAG_LIMIT   = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [ROOT_W:0]   rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqrt_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [DATA_W-1:0] num;
    logic [ROOT_W-1:0] den;
    logic              ovf;
  } quo_t;

  // floor(m*m / 2^24)
  function automatic logic [SQ_W-1:0] sq_q824(input logic [DATA_W-1:0] m);
    logic [2*DATA_W-1:0] p;
    p = m * m;
    return p[SQ_W+FRAC_W-1:FRAC_W];
  endfunction

  // drop the Q0.16 scale and clamp to the positive 32-bit range
  function automatic logic [DATA_W-1:0] avg_clamp(input logic [ACC_W-1:0] acc);
    logic [ACC_W-RHO_W-1:0] s;
    s = acc[ACC_W-1:RHO_W];
    if (|s[ACC_W-RHO_W-1:DATA_W-1]) begin
      return AVG_MAX;
    end
    return {1'b0, s[DATA_W-2:0]};
  endfunction

  function automatic sqrt_t sqrt_steps(input sqrt_t s);
    logic [ROOT_W+2:0] r2;
    logic [ROOT_W+2:0] trial;
    sqrt_t t;
    t = s;
    for (int j = 0; j < SQRT_BPS; j++) begin
      r2    = {t.rem, t.rad[RAD_W-1 -: 2]};
      trial = {1'b0, t.root, 2'b01};
      t.rad = {t.rad[RAD_W-3:0], 2'b00};
      if (r2 >= trial) begin
        r2     = r2 - trial;
        t.root = {t.root[ROOT_W-2:0], 1'b1};
      end else begin
        t.root = {t.root[ROOT_W-2:0], 1'b0};
      end
      t.rem = r2[ROOT_W:0];
    end
    return t;
  endfunction

  function automatic quo_t quo_steps(input quo_t s);
    logic [ROOT_W:0] r2;
    quo_t t;
    t = s;
    for (int j = 0; j < DIV_BPS; j++) begin
      r2    = {t.rem, t.num[DATA_W-1]};
      t.num = {t.num[DATA_W-2:0], 1'b0};
      if (r2 >= {1'b0, t.den}) begin
        r2       = r2 - {1'b0, t.den};
        t.num[0] = 1'b1;
      end
      t.rem = r2[ROOT_W-1:0];
    end
    return t;
  endfunction

endpackage

// ----- rtl/core/adpu_isqrt.sv -----
// Pipelined integer square root, four result bits per stage.
// Depends on adpu_pkg (sqrt_t, sqrt_steps).
module adpu_isqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [adpu_pkg::RAD_W-1:0]  rad_i,
  output logic [adpu_pkg::ROOT_W-1:0] root_o
);
  import adpu_pkg::*;

  sqrt_t src [SQRT_STG];
  sqrt_t st_q [SQRT_STG];

  always_comb begin
    src[0] = '{rem: '0, root: '0, rad: rad_i};
    for (int s = 1; s < SQRT_STG; s++) begin
      src[s] = st_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < SQRT_STG; s++) begin
        st_q[s] <= sqrt_steps(src[s]);
      end
    end
  end

  assign root_o = st_q[SQRT_STG-1].root;

endmodule

// ----- rtl/core/adpu_div.sv -----
// Pipelined restoring divider, four quotient bits per stage, with overflow flag.
// Depends on adpu_pkg (quo_t, quo_steps).
module adpu_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [adpu_pkg::PROD_W-1:0] num_i,
  input  logic [adpu_pkg::ROOT_W-1:0] den_i,
  output logic [adpu_pkg::DATA_W-1:0] quo_o,
  output logic                        ovf_o
);
  import adpu_pkg::*;

  quo_t src [DIV_STG];
  quo_t st_q [DIV_STG];

  always_comb begin
    src[0] = '{rem: num_i[PROD_W-1:DATA_W], num: num_i[DATA_W-1:0], den: den_i,
               ovf: (num_i[PROD_W-1:DATA_W] >= den_i)};
    for (int s = 1; s < DIV_STG; s++) begin
      src[s] = st_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DIV_STG; s++) begin
        st_q[s] <= quo_steps(src[s]);
      end
    end
  end

  assign quo_o = st_q[DIV_STG-1].num;
  assign ovf_o = st_q[DIV_STG-1].ovf;

endmodule

// ----- rtl/core/adadelta_param_update_unit.sv -----
// Adadelta weight update unit: top level, per-element state memories and pipeline.
// Depends on adpu_pkg, adpu_isqrt and adpu_div.
//
//  channel | direction | handshake             | payload
//  in      | sink      | in_valid_i/in_ready_o | element_index_i, gradient_i, weight_in_i
//  out     | source    | out_valid_o/out_ready_i | weight_out_o, step_taken_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while no stall holds the pipeline; the two square roots
// (7 stages) and the divider (8 stages) set the depth.
// After reset both state memories are swept to zero, one entry a cycle, with
// in_ready_o low until all 4096 entries are cleared.
// An item whose element is still in flight waits until that element is written back.
// A stall on out freezes the whole pipeline.
module adadelta_param_update_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [adpu_pkg::IN_IDX_W-1:0]      element_index_i,
  input  logic signed [adpu_pkg::DATA_W-1:0] gradient_i,
  input  logic signed [adpu_pkg::DATA_W-1:0] weight_in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [adpu_pkg::DATA_W-1:0] weight_out_o,
  output logic signed [adpu_pkg::DATA_W-1:0] step_taken_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [adpu_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [adpu_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import adpu_pkg::*;

  localparam int unsigned ST_IN    = 1;
  localparam int unsigned ST_SQG   = 2;
  localparam int unsigned ST_ACC   = 3;
  localparam int unsigned ST_GNEW  = 4;
  localparam int unsigned ST_RAD   = 5;
  localparam int unsigned ST_ROOT  = ST_RAD + SQRT_STG;
  localparam int unsigned ST_PROD  = ST_ROOT + 1;
  localparam int unsigned ST_QUO   = ST_PROD + DIV_STG;
  localparam int unsigned ST_DELTA = ST_QUO + 1;
  localparam int unsigned ST_USQ   = ST_DELTA + 1;
  localparam int unsigned ST_LAST  = ST_USQ + 1;

  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic              neg;
    logic [DATA_W-1:0] gmag;
    logic [DATA_W-1:0] weight;
    logic [DATA_W-1:0] uold;
    logic [DATA_W-1:0] gnew;
    logic              bzero;
  } side_t;

  // configuration
  logic [RHO_W-1:0] rho_q;
  logic [EPS_W-1:0] eps_q;
  logic [RHO_W:0]   one_m_rho;

  assign cfg_ready_o = 1'b1;
  assign one_m_rho   = ONE_Q16 - {1'b0, rho_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rho_q <= DECAY_RESET;
      eps_q <= STAB_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DECAY_RATE:     rho_q <= cfg_data_i[RHO_W-1:0];
        REG_STABILITY_TERM: eps_q <= cfg_data_i[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing sweep
  logic             clr_q;
  logic [IDX_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == IDX_W'(ELEMENTS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // handshake
  side_t            side_q [1:ST_LAST];
  side_t            side_d [1:ST_LAST];
  logic             out_valid_q;
  logic             adv;
  logic             hazard;
  logic             in_fire;
  logic [IDX_W-1:0] in_idx;
  logic [DATA_W-1:0] in_gmag;

  assign in_idx     = element_index_i[IDX_W-1:0];
  assign in_gmag    = gradient_i[DATA_W-1] ? DATA_W'(-gradient_i) : DATA_W'(gradient_i);
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv && !clr_q && !hazard;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= ST_LAST; k++) begin
      if (side_q[k].vld && (side_q[k].idx == in_idx)) begin
        hazard = 1'b1;
      end
    end
  end

  // state memories
  logic [DATA_W-1:0] g_mem [ELEMENTS];
  logic [DATA_W-1:0] u_mem [ELEMENTS];
  logic [DATA_W-1:0] g_rd_q;
  logic [DATA_W-1:0] u_rd_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [DATA_W-1:0] g_wd;
  logic [DATA_W-1:0] u_wd;
  logic [DATA_W-1:0] u_new;

  assign mem_we = clr_q || (adv && side_q[ST_LAST].vld);
  assign mem_wa = clr_q ? clr_cnt_q : side_q[ST_LAST].idx;
  assign g_wd   = clr_q ? '0 : side_q[ST_LAST].gnew;
  assign u_wd   = clr_q ? '0 : u_new;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      g_mem[mem_wa] <= g_wd;
      u_mem[mem_wa] <= u_wd;
    end
    if (in_fire) begin
      g_rd_q <= g_mem[in_idx];
      u_rd_q <= u_mem[in_idx];
    end
  end

  // arithmetic stages
  logic [SQ_W-1:0]   sqg_q;
  logic [DATA_W-1:0] gold_q;
  logic [PA_W-1:0]   pg_a_q;
  logic [PB_W-1:0]   pg_b_q;
  logic [DATA_W-1:0] rad_a3_q;
  logic [DATA_W-1:0] rad_a4_q;
  logic [DATA_W-1:0] rad_a5_q;
  logic [DATA_W-1:0] rad_b5_q;
  logic [DATA_W-1:0] b_sum;
  logic [ROOT_W-1:0] root_a;
  logic [ROOT_W-1:0] root_b;
  logic [PROD_W-1:0] prod_q;
  logic [ROOT_W-1:0] sb_q;
  logic [DATA_W-1:0] quo;
  logic              quo_ovf;
  logic [DATA_W-1:0] mag_c;
  logic [DATA_W-1:0] delta_d;
  logic [DATA_W-1:0] dmag_d;
  logic [DATA_W-1:0] delta_q;
  logic [DATA_W-1:0] dmag_q;
  logic [SQ_W-1:0]   sqd_q;
  logic [DATA_W:0]   wsum;
  logic [DATA_W-1:0] wsat;
  logic [DATA_W-1:0] wout23_q;
  logic [DATA_W-1:0] delta23_q;
  logic [PA_W-1:0]   pu_a_q;
  logic [PB_W-1:0]   pu_b_q;
  logic [DATA_W-1:0] wout24_q;
  logic [DATA_W-1:0] delta24_q;
  logic [DATA_W-1:0] weight_out_q;
  logic [DATA_W-1:0] step_q;

  assign b_sum = side_q[ST_GNEW].gnew + DATA_W'(eps_q);
  assign u_new = avg_clamp(ACC_W'(pu_a_q) + ACC_W'(pu_b_q));

  always_comb begin
    side_d[ST_IN]        = '0;
    side_d[ST_IN].vld    = in_fire;
    side_d[ST_IN].idx    = in_idx;
    side_d[ST_IN].neg    = gradient_i[DATA_W-1];
    side_d[ST_IN].gmag   = in_gmag;
    side_d[ST_IN].weight = weight_in_i;
    for (int k = 2; k <= ST_LAST; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[ST_SQG].uold  = u_rd_q;
    side_d[ST_GNEW].gnew = avg_clamp(ACC_W'(pg_a_q) + ACC_W'(pg_b_q));
    side_d[ST_RAD].bzero = (b_sum == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= ST_LAST; k++) begin
        side_q[k] <= '0;
      end
    end else if (adv) begin
      for (int k = 1; k <= ST_LAST; k++) begin
        side_q[k] <= side_d[k];
      end
    end
  end

  adpu_isqrt u_sqrt_a (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  ({rad_a5_q, FRAC_W'(0)}),
    .root_o (root_a)
  );

  adpu_isqrt u_sqrt_b (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  ({rad_b5_q, FRAC_W'(0)}),
    .root_o (root_b)
  );

  adpu_div u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (prod_q),
    .den_i (sb_q),
    .quo_o (quo),
    .ovf_o (quo_ovf)
  );

  always_comb begin
    mag_c = (quo_ovf || (quo > MAG_LIMIT)) ? MAG_LIMIT : quo;
    if (side_q[ST_QUO].bzero) begin
      dmag_d  = '0;
      delta_d = '0;
    end else if (side_q[ST_QUO].neg) begin
      dmag_d  = (mag_c == MAG_LIMIT) ? AVG_MAX : mag_c;
      delta_d = dmag_d;
    end else begin
      dmag_d  = mag_c;
      delta_d = ~mag_c + 1'b1;
    end
  end

  always_comb begin
    wsum = {side_q[ST_DELTA].weight[DATA_W-1], side_q[ST_DELTA].weight}
         + {delta_q[DATA_W-1], delta_q};
    if (wsum[DATA_W] != wsum[DATA_W-1]) begin
      wsat = wsum[DATA_W] ? MAG_LIMIT : AVG_MAX;
    end else begin
      wsat = wsum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqg_q     <= sq_q824(side_q[ST_IN].gmag);
      gold_q    <= g_rd_q;
      pg_a_q    <= PA_W'(rho_q) * PA_W'(gold_q);
      pg_b_q    <= PB_W'(one_m_rho) * PB_W'(sqg_q);
      rad_a3_q  <= side_q[ST_SQG].uold + DATA_W'(eps_q);
      rad_a4_q  <= rad_a3_q;
      rad_a5_q  <= rad_a4_q;
      rad_b5_q  <= b_sum;
      prod_q    <= PROD_W'(root_a) * PROD_W'(side_q[ST_ROOT].gmag);
      sb_q      <= root_b;
      delta_q   <= delta_d;
      dmag_q    <= dmag_d;
      sqd_q     <= sq_q824(dmag_q);
      wout23_q  <= wsat;
      delta23_q <= delta_q;
      pu_a_q    <= PA_W'(rho_q) * PA_W'(side_q[ST_USQ].uold);
      pu_b_q    <= PB_W'(one_m_rho) * PB_W'(sqd_q);
      wout24_q  <= wout23_q;
      delta24_q <= delta23_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= side_q[ST_LAST].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      weight_out_q <= wout24_q;
      step_q       <= delta24_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign weight_out_o = weight_out_q;
  assign step_taken_o = step_q;

endmodule

// ----- rtl/core/adpu_checker.sv -----
// Port-level checks for the Adadelta update unit, bound to the top level.
// Depends on adpu_pkg and adadelta_param_update_unit.
module adpu_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [adpu_pkg::IN_IDX_W-1:0]      element_index_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [adpu_pkg::DATA_W-1:0] weight_out_o,
  input logic signed [adpu_pkg::DATA_W-1:0] step_taken_o
);
  import adpu_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(weight_out_o) && $stable(step_taken_o))
    else $error("result item dropped or changed while stalled");

  a_ready_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("input taken while the pipeline is frozen");

  a_sweep_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_o)
    else $error("input taken before the state sweep");

  a_no_same_element: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && $past(in_valid_i && in_ready_o)) |->
      (element_index_i[IDX_W-1:0] != $past(element_index_i[IDX_W-1:0])))
    else $error("element accepted while its update is in flight");

endmodule

bind adadelta_param_update_unit adpu_checker u_adpu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .element_index_i (element_index_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .weight_out_o    (weight_out_o),
  .step_taken_o    (step_taken_o)
);

// ----- test/testbench.sv -----
// Self-checking testbench for adadelta_param_update_unit: directed table, then random
// streams under several idling patterns, checked against an in-bench Adadelta predictor.
// Depends on adpu_pkg and the RTL of the update unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import adpu_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int HOLD_LEN = 300;
  localparam int DRAIN    = 40;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [IN_IDX_W-1:0]      element_index_i = '0;
  logic signed [DATA_W-1:0] gradient_i = '0;
  logic signed [DATA_W-1:0] weight_in_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] weight_out_o;
  logic signed [DATA_W-1:0] step_taken_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i = '0;

  adadelta_param_update_unit DUT (.*);

  typedef struct packed {
    logic signed [DATA_W-1:0] weight;
    logic signed [DATA_W-1:0] step;
  } upd_t;

  typedef struct {
    logic [IN_IDX_W-1:0]      idx;
    logic signed [DATA_W-1:0] grad;
    logic signed [DATA_W-1:0] w;
    bit                       typed;
    upd_t                     res;
  } row_t;

  logic [DATA_W-1:0] g_avg [ELEMENTS];
  logic [DATA_W-1:0] u_avg [ELEMENTS];
  logic [RHO_W-1:0]  rho = DECAY_RESET;
  logic [EPS_W-1:0]  eps = STAB_RESET;
  upd_t              pending_upd [$];

  int tx_pct = 0;
  int rx_pct = 0;
  int hold_tok = 0;
  int fails = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] blend_avg(input logic [DATA_W-1:0] avg,
                                                  input longint unsigned mag);
    longint unsigned sq, acc;
    sq  = (mag * mag) >> FRAC_W;
    acc = (64'(rho) * avg + (64'd65536 - rho) * sq) >> RHO_W;
    return (acc > AVG_MAX) ? AVG_MAX : acc[DATA_W-1:0];
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic upd_t adadelta_update(input logic [IN_IDX_W-1:0] idx,
                                           input logic signed [DATA_W-1:0] grad,
                                           input logic signed [DATA_W-1:0] w);
    longint g, d, gmag, mag;
    longint unsigned a, b, sa, sb;
    logic [DATA_W-1:0] g_new, u_old;
    upd_t r;
    g     = grad;
    gmag  = g < 0 ? -g : g;
    g_new = blend_avg(g_avg[idx], gmag);
    g_avg[idx] = g_new;
    u_old = u_avg[idx];
    a = 64'(u_old) + eps;
    b = 64'(g_new) + eps;
    if (b == 0) begin
      d = 0;
    end else begin
      sa  = root64(a << FRAC_W);
      sb  = root64(b << FRAC_W);
      mag = (sa * gmag) / sb;
      if (mag > 64'h80000000) mag = 64'h80000000;
      d = sat32(g >= 0 ? -mag : mag);
    end
    u_avg[idx] = blend_avg(u_old, d < 0 ? -d : d);
    r.weight = DATA_W'(sat32(64'(w) + d));
    r.step   = DATA_W'(d);
    return r;
  endfunction

  // called at a rising edge; returns at the edge that accepts the item
  task automatic send_item(input row_t row);
    upd_t p;
    if ($urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_pct);
    end
    in_valid_i      <= 1'b1;
    element_index_i <= row.idx;
    gradient_i      <= row.grad;
    weight_in_i     <= row.w;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    p = adadelta_update(row.idx, row.grad, row.w);
    pending_upd.push_back(row.typed ? row.res : p);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_upd.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_DECAY_RATE) rho = d[RHO_W-1:0];
    else if (idx == REG_STABILITY_TERM) eps = d[EPS_W-1:0];
  endtask

  task automatic random_phase(input int n);
    row_t row;
    for (int i = 0; i < n; i++) begin
      row.typed = 1'b0;
      row.res   = '0;
      row.idx   = ($urandom_range(3) == 0) ? IN_IDX_W'($urandom) : IN_IDX_W'($urandom_range(7));
      case ($urandom_range(5))
        0:       row.grad = '0;
        1, 2:    row.grad = $signed(DATA_W'($urandom_range(65535))) - 32768;
        3:       row.grad = $signed(DATA_W'($urandom_range(33554431))) - 16777216;
        default: row.grad = $urandom;
      endcase
      row.w = $urandom;
      send_item(row);
      if (i == n / 2) drain();
    end
  endtask

  // receiver, with a long hold-off on request
  initial begin
    int hold_seen = 0;
    int hold_cnt  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_tok != hold_seen) begin
        hold_seen = hold_tok;
        hold_cnt  = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_pct);
      end
    end
  end

  // checker and watchdog
  initial begin
    int quiet = 0;
    upd_t e;
    forever begin
      @(negedge clk_i);
      quiet++;
      if ((in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o)) quiet = 0;
      if (out_valid_o && out_ready_i) begin
        quiet = 0;
        if (pending_upd.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result w=%h s=%h", weight_out_o, step_taken_o);
        end else begin
          e = pending_upd.pop_front();
          if (weight_out_o !== e.weight || step_taken_o !== e.step) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: w exp %h got %h, s exp %h got %h",
                       e.weight, weight_out_o, e.step, step_taken_o);
          end
        end
      end
      if (quiet >= WATCHDOG) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    row_t tbl [$];
    row_t row;
    tbl = '{
      '{12'd0,    32'sd0, 32'h7FFFFFFF, 1'b1, '{32'h7FFFFFFF, 32'sd0}},
      '{12'd4095, 32'sd0, 32'h80000000, 1'b1, '{32'h80000000, 32'sd0}},
      '{12'd1, 32'h7FFFFFFF, 32'sd0,       1'b0, '0},
      '{12'd2, 32'h80000000, 32'h7FFFFFFF, 1'b0, '0},
      '{12'd1, 32'h80000000, 32'h80000000, 1'b0, '0},
      '{12'd1, 32'h7FFFFFFF, 32'h80000000, 1'b0, '0},
      '{12'd3, 32'sd1,       -32'sd1,      1'b0, '0},
      '{12'd3, -32'sd1,      32'sd1,       1'b0, '0},
      '{12'd4, 32'h01000000, 32'h01000000, 1'b0, '0},
      '{12'd4, 32'h01000000, 32'h01000000, 1'b0, '0},
      '{12'd4, -32'sh01000000, 32'h7FFFFFF0, 1'b0, '0},
      '{12'd4095, 32'h00100000, 32'h80000010, 1'b0, '0}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (g_avg[i]) begin
      g_avg[i] = '0;
      u_avg[i] = '0;
    end
    @(posedge clk_i);
    foreach (tbl[i]) send_item(tbl[i]);
    drain();
    // zero divisor: epsilon zero on an untouched element
    write_reg(REG_STABILITY_TERM, '0);
    write_reg(REG_DECAY_RATE, '0);
    row = '{12'd100, 32'sd0, 32'h12345678, 1'b1, '{32'h12345678, 32'sd0}};
    send_item(row);
    row = '{12'd100, 32'h00800000, 32'h0, 1'b0, '0};
    send_item(row);
    drain();
    write_reg(REG_DECAY_RATE, 32'hFFFF);
    write_reg(REG_STABILITY_TERM, 32'h1FFFFF);
    write_reg(2'd2, 32'h0);
    write_reg(2'd3, 32'h1);
    foreach (tbl[i]) if (!tbl[i].typed) send_item(tbl[i]);
    drain();

    tx_pct = 28;
    rx_pct = 50;
    write_reg(REG_DECAY_RATE, 32'(DECAY_RESET));
    write_reg(REG_STABILITY_TERM, 32'(STAB_RESET));
    hold_tok++;
    random_phase(130);
    drain();
    tx_pct = 50;
    rx_pct = 28;
    write_reg(REG_DECAY_RATE, $urandom_range(65535));
    write_reg(REG_STABILITY_TERM, $urandom_range(1677721));
    random_phase(130);
    drain();
    tx_pct = 0;
    rx_pct = 0;
    write_reg(REG_DECAY_RATE, 32'd1);
    write_reg(REG_STABILITY_TERM, 32'd1677721);
    random_phase(130);
    drain();
    if (fails == 0 && pending_upd.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/adpu_pkg.sv
rtl/core/adpu_isqrt.sv
rtl/core/adpu_div.sv
rtl/core/adadelta_param_update_unit.sv
rtl/core/adpu_checker.sv
test/testbench.sv
